// ----- src/button_press_classifier_core_macros.svh -----
// assertion macros for the button press classifier core
`ifndef BUTTON_PRESS_CLASSIFIER_CORE_MACROS_SVH
`define BUTTON_PRESS_CLASSIFIER_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define BPC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define BPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/bpc_pkg.sv -----
// types and constants shared by the button press classifier modules
package bpc_pkg;

    localparam int DEBOUNCE_W = 4;
    localparam int COUNT_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int EVENT_W    = 3;

    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TICKS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_TICKS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS       = 2'd2;

    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET   = 4'd2;
    localparam logic [COUNT_W-1:0]    LONG_PRESS_RESET = 16'd15;
    localparam logic [COUNT_W-1:0]    HOLD_RESET       = 16'd50;
    localparam logic [COUNT_W-1:0]    COUNT_MAX        = 16'hFFFF;

    localparam logic [EVENT_W-1:0] EV_NONE         = 3'd0;
    localparam logic [EVENT_W-1:0] EV_FAST_PRESS   = 3'd1;
    localparam logic [EVENT_W-1:0] EV_SHORT_PRESS  = 3'd2;
    localparam logic [EVENT_W-1:0] EV_LONG_PRESS   = 3'd3;
    localparam logic [EVENT_W-1:0] EV_RELEASE_HOLD = 3'd4;

    typedef struct packed {
        logic [DEBOUNCE_W-1:0] debounce_ticks;
        logic [COUNT_W-1:0]    long_press_ticks;
        logic [COUNT_W-1:0]    hold_ticks;
    } bpc_cfg_t;

    typedef struct packed {
        logic                  idle_waiting;
        logic [DEBOUNCE_W-1:0] tick_countdown;
        logic                  press_confirmed;
        logic                  release_seen;
        logic [COUNT_W-1:0]    held_count;
        logic                  long_flag;
        logic                  hold_flag;
    } bpc_state_t;

    typedef struct packed {
        logic                  hold_active;
        logic [EVENT_W-1:0]    event_code;
    } bpc_result_t;

endpackage

// ----- src/button_press_classifier_core.sv -----
// top level of the button press classifier: debounce, press classification, hold flag
//
//  channel  | ports                              | payload
//  ---------+------------------------------------+------------------------------------
//  input    | s_tvalid s_tready s_tdata[7:0]     | [0] button_pressed
//  result   | m_tvalid m_tready m_tdata[7:0]     | [2:0] event_code, [3] hold_active
//  config   | cfg_valid cfg_ready cfg_index cfg_data | index 0..2, data 16 bit
//
// each sample goes input register -> step logic -> result register; one sample per cycle
// sustained while the result is not stalled, set by the single state update in the step logic.
// synchronous active-low reset, no clearing pass; the config port is always ready.
// a stalled result holds the input register, which in turn drops s_tready.
module button_press_classifier_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [0] button_pressed, [7:1] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [2:0] event_code, [3] hold_active, [7:4] zero
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import bpc_pkg::*;
    `include "button_press_classifier_core_macros.svh"

    bpc_cfg_t    cfg;
    bpc_state_t  state_reg;
    bpc_state_t  state_next;
    bpc_result_t step_res;
    bpc_result_t res_reg;
    logic        in_valid_reg;
    logic        in_pressed_reg;
    logic        out_valid_reg;
    logic        advance;

    assign cfg_ready = 1'b1;

    bpc_cfg_regs u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid & cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    bpc_step u_step (
        .cfg     (cfg),
        .cur     (state_reg),
        .pressed (in_pressed_reg),
        .nxt     (state_next),
        .res     (step_res)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_pressed_reg <= s_tdata[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.idle_waiting    <= 1'b1;
            state_reg.tick_countdown  <= DEBOUNCE_RESET;
            state_reg.press_confirmed <= 1'b0;
            state_reg.release_seen    <= 1'b0;
            state_reg.held_count      <= '0;
            state_reg.long_flag       <= 1'b0;
            state_reg.hold_flag       <= 1'b0;
            out_valid_reg             <= 1'b0;
        end else begin
            if (advance) begin
                state_reg <= state_next;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= step_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, res_reg.hold_active, res_reg.event_code};

    `BPC_ASSERT_IMPLY(a_hold_cleared_on_release, aclk, aresetn,
        m_tvalid && m_tdata[2:0] == EV_RELEASE_HOLD, !m_tdata[3],
        "hold still active on release-after-hold event")
    `BPC_ASSERT_IMPLY(a_idle_clean, aclk, aresetn,
        state_reg.idle_waiting,
        state_reg.held_count == '0 && !state_reg.long_flag && !state_reg.hold_flag,
        "press state left over while idle")
    `BPC_ASSERT_IMPLY(a_code_range, aclk, aresetn,
        m_tvalid, m_tdata[2:0] <= EV_RELEASE_HOLD && m_tdata[7:4] == 4'd0,
        "result code out of range")
    `BPC_ASSERT_NEXT(a_result_follows_step, aclk, aresetn,
        advance, m_tvalid,
        "stepped sample produced no result")
endmodule

// ----- src/bpc_cfg_regs.sv -----
// configuration register file of the button press classifier
module bpc_cfg_regs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            wr_en,
    input  logic [bpc_pkg::CFG_IDX_W-1:0]   wr_index,
    input  logic [bpc_pkg::CFG_DATA_W-1:0]  wr_data,
    output bpc_pkg::bpc_cfg_t               cfg
);
    import bpc_pkg::*;

    bpc_cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_ticks   <= DEBOUNCE_RESET;
            cfg_reg.long_press_ticks <= LONG_PRESS_RESET;
            cfg_reg.hold_ticks       <= HOLD_RESET;
        end else if (wr_en) begin
            unique case (wr_index)
                REG_DEBOUNCE_TICKS:   cfg_reg.debounce_ticks   <= wr_data[DEBOUNCE_W-1:0];
                REG_LONG_PRESS_TICKS: cfg_reg.long_press_ticks <= wr_data;
                REG_HOLD_TICKS:       cfg_reg.hold_ticks       <= wr_data;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;
endmodule

// ----- src/bpc_step.sv -----
// next-state and event logic for one sampled button level
module bpc_step (
    input  bpc_pkg::bpc_cfg_t    cfg,
    input  bpc_pkg::bpc_state_t  cur,
    input  logic                 pressed,
    output bpc_pkg::bpc_state_t  nxt,
    output bpc_pkg::bpc_result_t res
);
    import bpc_pkg::*;

    always_comb begin
        logic                  run;
        logic                  sample;
        logic [COUNT_W-1:0]    held_inc;
        logic [EVENT_W-1:0]    ev;

        nxt    = cur;
        ev     = EV_NONE;
        run    = 1'b1;
        sample = 1'b0;
        held_inc = (cur.held_count != COUNT_MAX) ? cur.held_count + 16'd1 : cur.held_count;

        if (cur.idle_waiting) begin
            if (!pressed) begin
                run = 1'b0;
            end else begin
                nxt.idle_waiting   = 1'b0;
                nxt.tick_countdown = cfg.debounce_ticks;
            end
        end

        if (run) begin
            // countdown wraps, so a zero setting acts as sixteen ticks
            nxt.tick_countdown = nxt.tick_countdown - 4'd1;
            if (nxt.tick_countdown == '0) begin
                sample = 1'b1;
                if (!cur.press_confirmed) begin
                    if (!pressed) begin
                        // bounce before confirmation, drop quietly
                        nxt.idle_waiting    = 1'b1;
                        nxt.release_seen    = 1'b0;
                        nxt.press_confirmed = 1'b0;
                        sample              = 1'b0;
                    end else begin
                        nxt.press_confirmed = 1'b1;
                        ev                  = EV_FAST_PRESS;
                    end
                end
            end
        end

        if (sample) begin
            if (!cur.release_seen) begin
                nxt.tick_countdown = cfg.debounce_ticks;
                if (pressed) begin
                    nxt.held_count = held_inc;
                    if (held_inc >= cfg.long_press_ticks && held_inc < cfg.hold_ticks)
                        nxt.long_flag = 1'b1;
                    if (held_inc >= cfg.hold_ticks)
                        nxt.hold_flag = 1'b1;
                end else begin
                    nxt.release_seen = 1'b1;
                end
            end else begin
                if (cur.hold_flag) begin
                    ev            = EV_RELEASE_HOLD;
                    nxt.hold_flag = 1'b0;
                end else if (cur.long_flag) begin
                    ev = EV_LONG_PRESS;
                end else begin
                    ev = EV_SHORT_PRESS;
                end
                nxt.long_flag       = 1'b0;
                nxt.held_count      = '0;
                nxt.idle_waiting    = 1'b1;
                nxt.release_seen    = 1'b0;
                nxt.press_confirmed = 1'b0;
            end
        end

        res.event_code  = ev;
        res.hold_active = nxt.hold_flag;
    end
endmodule
